/* rtl/core/vssa_pkg.sv */
`default_nettype none
package vssa_pkg;

	localparam int NUM_SLOTS = 128;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int PADDR_W   = 1;

	// register byte addresses
	localparam logic [PADDR_W-1:0] REG_VIEW_ENTITY = '0;

	// command codes
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// sub-channel codes
	localparam logic [3:0] SUB_NONE = 4'h0;
	localparam logic [3:0] SUB_ANY  = 4'hf;

	// remaining-time compare is done unsigned on sign-flipped values
	localparam logic [31:0] SIGN_BIAS  = 32'h8000_0000;
	localparam logic [31:0] LIFE_START = 32'h7fff_ffff;
	localparam logic [31:0] BEST_INIT  = LIFE_START ^ SIGN_BIAS;

	typedef struct packed {
		logic              cmd;
		logic [15:0]       entity;
		logic signed [3:0] ent_channel;
		logic signed [31:0] end_time;
		logic signed [31:0] now_time;
		logic [6:0]        release_slot;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic [6:0] slot;
	} rsp_t;

	typedef struct packed {
		logic [15:0] owner;
		logic [3:0]  subch;
		logic [31:0] end_t;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		entry_t            entry;
	} slot_wr_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [SLOT_W-1:0] pick;
	} scan_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* rtl/core/voice_slot_stealing_allocator_core.sv */
// Voice slot allocator with stealing.
// Request channel (req_valid / req_stall / req): cmd 0 allocates a slot for
// an entity and sub-channel, cmd 1 releases slot release_slot.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one response per
// request, granted and slot index (slot 0 when nothing was granted).
// An allocate reads every slot from the slot store, one per cycle through a
// registered read port, and stops early on a same-entity match, so it ends
// sooner on an early match. The granted slot is written back on the cycle
// the scan ends. A release needs no scan and goes straight to the response.
// One request is in flight at a time: req_stall is high from acceptance until
// its response is loaded into the output register. A response waiting under
// rsp_stall does not block the next request; only the one after it waits.
// Reset clears all slots at once (valid and active flags in flip-flops), the
// view entity register, and any pending response; no clearing pass is needed.
// The user must write view_entity through APB address 0 only while idle; unchecked.
`default_nettype none
module voice_slot_stealing_allocator_core import vssa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_t                    rsp
);

	state_t        state_q;
	state_t        state_d;
	logic [15:0]   view_entity_q;
	req_t          req_q;
	rsp_t          res_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic          accept;
	logic          in_range;
	logic          start;
	logic          rel_en;
	logic          load_out;
	slot_wr_t      st_wr;
	logic          st_rd_en;
	logic [SLOT_W-1:0] st_rd_addr;
	entry_t        st_rd_entry;
	logic          st_rd_active;
	scan_status_t  scan_st;

	assign accept   = req_valid && !req_stall;
	assign in_range = 32'(req.release_slot) < NUM_SLOTS;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_VIEW_ENTITY) ? {16'b0, view_entity_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_entity_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == REG_VIEW_ENTITY)) begin
			view_entity_q <= pwdata[15:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (req.cmd == CMD_ALLOC) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_st.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_stall   = (state_q != ST_IDLE);
		start       = accept && (req.cmd == CMD_ALLOC);
		rel_en      = accept && (req.cmd == CMD_RELEASE) && in_range;
		load_out    = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
		st_wr.we    = (state_q == ST_SCAN) && scan_st.done && scan_st.found;
		st_wr.addr  = scan_st.pick;
		st_wr.entry = '{owner: req_q.entity, subch: req_q.ent_channel,
			end_t: req_q.end_time};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the request and build its response
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q         <= req;
			res_q.granted <= in_range;
			res_q.slot    <= in_range ? req.release_slot : 7'd0;
		end
		if ((state_q == ST_SCAN) && scan_st.done) begin
			res_q.granted <= scan_st.found;
			res_q.slot    <= scan_st.found ? 7'(scan_st.pick) : 7'd0;
		end
		if (load_out) begin
			rsp_q <= res_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	vssa_slot_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (st_wr),
		.rel_en    (rel_en),
		.rel_addr  (SLOT_W'(req.release_slot)),
		.rd_en     (st_rd_en),
		.rd_addr   (st_rd_addr),
		.rd_entry  (st_rd_entry),
		.rd_active (st_rd_active)
	);

	// the scan compares against the held request, not the live input
	vssa_scan_unit u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.entity      (req_q.entity),
		.sub         (req_q.ent_channel),
		.now_time    (req_q.now_time),
		.view_entity (view_entity_q),
		.rd_entry    (st_rd_entry),
		.rd_active   (st_rd_active),
		.rd_en       (st_rd_en),
		.rd_addr     (st_rd_addr),
		.status      (scan_st)
	);

`ifndef ASSERT_OFF
	// a response without a grant carries slot 0
	a_nogrant_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.granted |-> rsp.slot == 7'd0)
		else $error("ungranted response with nonzero slot");

	// the scan finishes only while the sequencer waits for it
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_st.done |-> state_q == ST_SCAN)
		else $error("scan done outside of scan state");

	// a write-back always leads to a granted response
	a_wr_grants: assert property (@(posedge clk) disable iff (!arst_n)
		st_wr.we |=> state_q == ST_DONE && res_q.granted)
		else $error("slot written without grant");
`endif

endmodule
`default_nettype wire

/* rtl/core/vssa_slot_store.sv */
`default_nettype none
module vssa_slot_store import vssa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slot_wr_t          wr,
	input  wire logic              rel_en,
	input  wire logic [SLOT_W-1:0] rel_addr,
	input  wire logic              rd_en,
	input  wire logic [SLOT_W-1:0] rd_addr,
	output entry_t                 rd_entry,
	output logic                   rd_active
);

	entry_t            mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	logic [NUM_SLOTS-1:0] active_q;
	entry_t            rd_data_s1;
	logic              rd_valid_s1;
	logic              rd_active_s1;

	// write the slot fields
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.entry;
		end
	end

	// read the slot fields into a register
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// track written and active slots; reset clears both at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			active_q     <= '0;
			rd_valid_s1  <= 1'b0;
			rd_active_s1 <= 1'b0;
		end else begin
			if (wr.we) begin
				valid_q[wr.addr]  <= 1'b1;
				active_q[wr.addr] <= 1'b1;
			end
			if (rel_en) begin
				active_q[rel_addr] <= 1'b0;
			end
			if (rd_en) begin
				rd_valid_s1  <= valid_q[rd_addr];
				rd_active_s1 <= active_q[rd_addr];
			end
		end
	end

	// a never-written slot reads as all zero
	assign rd_entry  = rd_valid_s1 ? rd_data_s1 : '0;
	assign rd_active = rd_active_s1;

endmodule
`default_nettype wire

/* rtl/core/vssa_scan_unit.sv */
`default_nettype none
module vssa_scan_unit import vssa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [15:0]       entity,
	input  wire logic [3:0]        sub,
	input  wire logic [31:0]       now_time,
	input  wire logic [15:0]       view_entity,
	input  wire entry_t            rd_entry,
	input  wire logic              rd_active,
	output logic                   rd_en,
	output logic [SLOT_W-1:0]      rd_addr,
	output scan_status_t           status
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	logic [SLOT_W-1:0] addr_q;
	logic              issue_q;
	logic              cmp_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [31:0]       best_q;
	logic [SLOT_W-1:0] pick_q;
	logic              found_q;

	logic              hit;
	logic              prot;
	logic [31:0]       left;
	logic              better;
	logic              take;

	// compare the slot that arrived from the store
	always_comb begin
		hit    = (sub != SUB_NONE) && (rd_entry.owner == entity) &&
			((rd_entry.subch == sub) || (sub == SUB_ANY));
		prot   = (rd_entry.owner == view_entity) && (entity != view_entity) && rd_active;
		left   = (rd_entry.end_t - now_time) ^ SIGN_BIAS;
		better = !hit && !prot && (left < best_q);
		take   = cmp_s1 && (hit || better);
	end

	assign rd_en        = issue_q;
	assign rd_addr      = addr_q;
	assign status.done  = cmp_s1 && (hit || (idx_s1 == LAST_SLOT));
	assign status.found = found_q || take;
	assign status.pick  = take ? idx_s1 : pick_q;

	// sequence reads over all slots; stop early on a same-entity hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			cmp_s1  <= 1'b0;
			found_q <= 1'b0;
			addr_q  <= '0;
		end else if (start) begin
			issue_q <= 1'b1;
			cmp_s1  <= 1'b0;
			found_q <= 1'b0;
			addr_q  <= '0;
		end else begin
			cmp_s1 <= issue_q && !(cmp_s1 && hit);
			if (issue_q) begin
				addr_q <= addr_q + 1'b1;
				if (addr_q == LAST_SLOT) begin
					issue_q <= 1'b0;
				end
			end
			if (cmp_s1 && hit) begin
				issue_q <= 1'b0;
			end
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	// hold the best candidate so far
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (start) begin
			best_q <= BEST_INIT;
			pick_q <= '0;
		end else if (cmp_s1 && better) begin
			best_q <= left;
			pick_q <= idx_s1;
		end
	end

endmodule
`default_nettype wire

/* verif/voice_alloc_checker.sv */
`timescale 1ns / 1ps
module voice_alloc_checker import vssa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic [31:0]        prdata,
	input  wire logic               pready,
	input  wire logic               req_valid,
	input  wire logic               req_stall,
	input  wire req_t               req,
	input  wire logic               rsp_valid,
	input  wire logic               rsp_stall,
	input  wire rsp_t               rsp,
	output int                      errors,
	output int                      pending,
	output int                      checked
);

	// mirror of the slot table and the listener register
	logic [15:0] owner_m [NUM_SLOTS];
	logic [3:0]  subch_m [NUM_SLOTS];
	logic [31:0] end_m   [NUM_SLOTS];
	logic        active_m[NUM_SLOTS];
	logic [15:0] listener;

	rsp_t grant_q[$];

	// work out the grant for one request and update the mirrored table
	task automatic predict_grant(input req_t r, output rsp_t g);
		logic [31:0] best;
		logic [31:0] left;
		logic [3:0]  ch;
		logic        any_ch;
		logic        hit;
		int          pick;
		g      = '0;
		ch     = r.ent_channel;
		any_ch = (ch == SUB_ANY);
		best   = BEST_INIT;
		hit    = 1'b0;
		pick   = 0;
		if (r.cmd == CMD_RELEASE) begin
			if (int'(r.release_slot) < NUM_SLOTS) begin
				active_m[r.release_slot] = 1'b0;
				g.granted = 1'b1;
				g.slot    = r.release_slot;
			end
		end else begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				// same entity and sub-channel takes the slot at once
				if (ch != SUB_NONE && owner_m[i] == r.entity &&
				    (subch_m[i] == ch || any_ch)) begin
					pick = i;
					hit  = 1'b1;
					break;
				end
				// skip active listener slots for other entities
				if (!(owner_m[i] == listener && r.entity != listener && active_m[i])) begin
					left = 32'(end_m[i] - r.now_time) ^ SIGN_BIAS;
					if (left < best) begin
						best = left;
						pick = i;
						hit  = 1'b1;
					end
				end
			end
			if (hit) begin
				owner_m[pick]  = r.entity;
				subch_m[pick]  = ch;
				end_m[pick]    = r.end_time;
				active_m[pick] = 1'b1;
				g.granted      = 1'b1;
				g.slot         = 7'(pick);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				owner_m[i]  = '0;
				subch_m[i]  = '0;
				end_m[i]    = '0;
				active_m[i] = 1'b0;
			end
			listener = '0;
			grant_q.delete();
			errors  = 0;
			pending = 0;
			checked = 0;
		end else begin
			// track register writes, check register reads
			if (psel && penable && pready && paddr == REG_VIEW_ENTITY) begin
				if (pwrite) begin
					listener = pwdata[15:0];
				end else if (prdata !== {16'h0, listener}) begin
					$display("%0t: view_entity read expected %h got %h",
						$time, {16'h0, listener}, prdata);
					errors++;
				end
			end
			// compare a delivered response with the oldest grant
			if (rsp_valid && !rsp_stall) begin
				got = rsp;
				if (grant_q.size() == 0) begin
					$display("%0t: response with none expected, got granted %0d slot %0d",
						$time, got.granted, got.slot);
					errors++;
				end else begin
					want = grant_q.pop_front();
					checked++;
					if (got.granted !== want.granted) begin
						$display("%0t: granted expected %0d got %0d",
							$time, want.granted, got.granted);
						errors++;
					end
					if (got.slot !== want.slot) begin
						$display("%0t: slot expected %0d got %0d",
							$time, want.slot, got.slot);
						errors++;
					end
				end
			end
			// predict each accepted request
			if (req_valid && !req_stall) begin
				predict_grant(req, want);
				grant_q.push_back(want);
			end
			pending = grant_q.size();
		end
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import vssa_pkg::*;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [31:0]        pwdata    = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;

	int errors;
	int pending;
	int checked;

	int          send_idle = 0;
	int          stall_pct = 0;
	int          hold_left = 0;
	int          sent      = 0;
	logic [15:0] view      = '0;
	logic [31:0] now_t     = '0;
	logic [15:0] rand_view;

	voice_slot_stealing_allocator_core uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	voice_alloc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// stall the response side at random, or hold off for a counted stretch
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left = hold_left - 1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin
		#20000000;
		$display("[voice_slot_stealing_allocator_core] ERROR");
		$finish;
	end

	function automatic req_t mk_req(input logic c, input logic [15:0] e,
		input logic [3:0] ch, input logic [31:0] et, input logic [31:0] nt,
		input logic [6:0] rs);
		req_t r;
		r.cmd          = c;
		r.entity       = e;
		r.ent_channel  = ch;
		r.end_time     = et;
		r.now_time     = nt;
		r.release_slot = rs;
		return r;
	endfunction

	// mostly a small entity pool and a slowly advancing clock, with full-range noise
	function automatic req_t random_req();
		req_t        r;
		logic [31:0] et;
		int          pick;
		now_t = now_t + $urandom_range(0, 300);
		if ($urandom_range(0, 99) < 5)
			now_t = $urandom;
		r.cmd = ($urandom_range(0, 99) < 30) ? CMD_RELEASE : CMD_ALLOC;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       r.entity = 16'($urandom);
			1:       r.entity = view;
			2:       r.entity = 16'hffff;
			default: r.entity = 16'($urandom_range(0, 5));
		endcase
		pick = $urandom_range(0, 9);
		if (pick < 2)
			r.ent_channel = SUB_ANY;
		else if (pick == 2)
			r.ent_channel = SUB_NONE;
		else
			r.ent_channel = 4'($urandom);
		pick = $urandom_range(0, 19);
		case (pick)
			0:       et = $urandom;
			1:       et = now_t + LIFE_START;
			2:       et = now_t - $urandom_range(0, 1000);
			default: et = now_t + $urandom_range(1, 5000);
		endcase
		r.end_time     = et;
		r.now_time     = now_t;
		r.release_slot = 7'($urandom_range(0, 127));
		return r;
	endfunction

	// offer one request and hold it until accepted
	task automatic push_request(input req_t r);
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	// stop offering and wait for every outstanding response
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// a setup phase and an access phase, then an idle bus
	task automatic apb_access(input logic wr, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REG_VIEW_ENTITY;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// write the listener while idle, then read it back
	task automatic set_listener(input logic [15:0] v);
		drain();
		apb_access(1'b1, {16'($urandom), v});
		apb_access(1'b0, '0);
		view = v;
	endtask

	task automatic run_phase(input int idle, input int stall, input logic [15:0] v,
		input bit long_hold);
		set_listener(v);
		send_idle = idle;
		stall_pct = stall;
		// listener fills the table with long sounds
		for (int i = 0; i < 140; i++) begin
			now_t = now_t + $urandom_range(0, 50);
			push_request(mk_req(CMD_ALLOC, view, SUB_NONE,
				now_t + 32'h6000_0000 + $urandom_range(0, 4095), now_t, 7'($urandom)));
		end
		// other entities now meet protected slots
		for (int i = 0; i < 20; i++)
			push_request(mk_req(CMD_ALLOC, view + 16'($urandom_range(1, 3)),
				4'($urandom_range(1, 15)), $urandom, now_t, 7'($urandom)));
		if (long_hold)
			hold_left = 600;
		for (int i = 0; i < 300; i++) begin
			if (i == 150)
				drain();
			push_request(random_req());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bound edge, matches, sub-channel patterns, releases
		set_listener(16'h0000);
		push_request(mk_req(CMD_ALLOC, 16'd1, 4'd2, 32'h0, 32'h8000_0001, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'd1, 4'd2, 32'd100, 32'h0, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'd1, 4'd2, 32'd200, 32'h0, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'd1, SUB_ANY, 32'd300, 32'h0, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'd1, SUB_NONE, 32'd400, 32'h0, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'hffff, 4'd7, 32'h7fff_ffff, 32'h8000_0000,
			7'h7f));
		push_request(mk_req(CMD_ALLOC, 16'h0, 4'h8, 32'h8000_0000, 32'h7fff_ffff, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'h0, 4'h8, 32'hffff_ffff, 32'h0, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'h0, 4'he, 32'h5555_5555, 32'haaaa_aaaa, 7'h55));
		push_request(mk_req(CMD_RELEASE, 16'($urandom), 4'($urandom), $urandom, $urandom,
			7'd0));
		push_request(mk_req(CMD_RELEASE, 16'hffff, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 7'd0));
		push_request(mk_req(CMD_RELEASE, 16'h0, 4'h0, 32'h0, 32'h0, 7'd127));
		push_request(mk_req(CMD_RELEASE, 16'h5555, 4'h5, 32'h0, 32'h0, 7'h55));
		push_request(mk_req(CMD_RELEASE, 16'haaaa, 4'ha, 32'h0, 32'h0, 7'h2a));
		set_listener(16'h0001);
		push_request(mk_req(CMD_ALLOC, 16'd2, 4'd3, 32'd1000, 32'h0, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'd1, 4'd4, 32'd5000, 32'h0, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'd2, 4'd5, 32'd10, 32'h0, 7'h0));
		push_request(mk_req(CMD_ALLOC, 16'd1, SUB_ANY, 32'd20, 32'h0, 7'h0));
		push_request(mk_req(CMD_RELEASE, 16'd1, 4'd0, 32'h0, 32'h0, 7'd1));
		push_request(mk_req(CMD_ALLOC, 16'd2, 4'd6, 32'd30, 32'h0, 7'h0));

		// random phases over the idle and stall mixes
		rand_view = 16'($urandom);
		run_phase(0, 0, 16'h0000, 1'b1);
		run_phase(52, 0, 16'hffff, 1'b0);
		run_phase(0, 52, rand_view, 1'b0);
		run_phase(31, 31, 16'h0003, 1'b0);

		drain();
		repeat (140) @(posedge clk);
		$display("covered %0d requests, %0d responses checked, over four idle/stall mixes",
			sent, checked);
		$display("view entity set to 0000, 0001, ffff, %h and 0003; long hold and drains included",
			rand_view);
		if (errors == 0 && pending == 0) begin
			$display("[voice_slot_stealing_allocator_core] OK");
		end else begin
			$display("[voice_slot_stealing_allocator_core] ERROR");
		end
		$finish;
	end

endmodule
